[design/tta_pkg.sv]
`timescale 1ns / 1ps

package tta_pkg;

  // Field widths
  localparam int ACCEL_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int DEADBAND_W = 4;
  localparam int DEGREE_W   = 7;
  localparam int DRIVE_W    = 2;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TARGET = 2'd1;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = 4'd3;
  localparam logic [DEGREE_W-1:0]   MAX_TARGET_RESET = 7'd90;
  localparam logic [BYTE_W-1:0]     FEATHER_RESET    = 8'd1;
  localparam logic [BYTE_W-1:0]     FEATHER_TRACK    = 8'd1;

  // Drive codes
  localparam logic [DRIVE_W-1:0] DRIVE_STOP    = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_EXTEND  = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_RETRACT = 2'd2;

  // Fixed angles in whole degrees
  localparam logic [DEGREE_W-1:0] ANGLE_ZERO  = 7'd0;
  localparam logic [DEGREE_W-1:0] ANGLE_RIGHT = 7'd90;
  localparam logic [DEGREE_W-1:0] ANGLE_HALF  = 7'd45;

  // CORDIC
  localparam int CORDIC_ITERATIONS_DEFAULT = 16;
  localparam int TABLE_LEN   = 24;
  localparam int STEP_W      = 5;
  localparam int ANGLE_FRAC  = 20;
  localparam int TAB_W       = 27;
  localparam int ANGLE_W     = 29;
  localparam int VEC_W       = 36;

  // atan(2^-i) in degrees, scaled by 2^20, rounded to nearest
  localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469358,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  // 90 degrees in the accumulator format
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 29'sd94371840;

endpackage

[design/tilt_tracking_actuator_control.sv]
`timescale 1ns / 1ps

// Tilt tracking actuator control. Each request carries one accelerometer
// sample and optionally a new feather byte and target byte, which take effect
// for that same request. The block returns the tilt elevation in whole degrees
// (truncated, 0..90), the effective target and a stop/extend/retract drive
// command with a configurable dead band. A request passes through squaring of
// y and then z on the shared multiplier, the bit-pair square root, a set-up
// step, CORDIC_ITERATIONS CORDIC rotations at one rotation per cycle, then
// clamping and the drive decision. A zero x, a zero horizontal magnitude or
// an |x| equal to it skips the rotations and clamping. The block returns to
// idle when the result is loaded and takes the next request from there, so it
// cannot take a new request before it is through with the last one. The
// block accepts one request at a time; a finished result waits in the output
// register while the next request is taken, and the next result is held back
// until that one is taken. Configuration writes are always ready and should
// be made while idle.
module tilt_tracking_actuator_control #(
  parameter int CORDIC_ITERATIONS = tta_pkg::CORDIC_ITERATIONS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [tta_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [tta_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [tta_pkg::ACCEL_W-1:0] accel_z,
  input  logic feather_valid,
  input  logic [tta_pkg::BYTE_W-1:0] feather_byte,
  input  logic target_valid,
  input  logic [tta_pkg::BYTE_W-1:0] target_byte,
  // result channel
  output logic out_valid,
  input  logic out_ready,
  output logic [tta_pkg::DRIVE_W-1:0] drive,
  output logic [tta_pkg::DEGREE_W-1:0] elevation_degrees,
  output logic [tta_pkg::DEGREE_W-1:0] effective_target,
  // configuration write channel
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tta_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = tta_pkg::ACCEL_W;
  localparam int MW = AW + 1;
  localparam int SW = tta_pkg::STEP_W;
  localparam int VW = tta_pkg::VEC_W;
  localparam int GW = tta_pkg::ANGLE_W;
  localparam int DW = tta_pkg::DEGREE_W;
  localparam int NW = 2 * AW;
  localparam logic [SW-1:0] LastStep = SW'(CORDIC_ITERATIONS - 1);

  typedef enum logic [2:0] {
    IDLE, SQ_Y, SQ_Z, ROOT, SETUP, ROTATE, CLAMP, FINISH
  } state_t;

  state_t state;

  // configuration and held bytes
  logic [tta_pkg::DEADBAND_W-1:0] deadband;
  logic [DW-1:0] max_target;
  logic [tta_pkg::BYTE_W-1:0] stored_feather;
  logic [tta_pkg::BYTE_W-1:0] stored_target;

  // working registers
  logic signed [AW-1:0] x_q, y_q, z_q;
  logic [DW-1:0] target_q;
  logic [NW-1:0] rad;
  logic [NW-1:0] root;
  logic [NW-1:0] root_bit;
  logic signed [VW-1:0] cx, cy;
  logic signed [GW-1:0] ang;
  logic [SW-1:0] step;
  logic [DW-1:0] elev;

  // select the bytes that arrive with a request, else the held ones, to evaluate the target
  logic [tta_pkg::BYTE_W-1:0] feather_next, target_next;
  logic [DW-1:0] eff_next;

  always_comb begin
    feather_next = feather_valid ? feather_byte : stored_feather;
    target_next  = target_valid ? target_byte : stored_target;
    if (feather_next == tta_pkg::FEATHER_TRACK &&
        {1'b0, target_next} <= {2'b0, max_target}) begin
      eff_next = target_next[DW-1:0];
    end else begin
      eff_next = tta_pkg::ANGLE_ZERO;
    end
  end

  // shared squaring multiplier: y in state SQ_Y, z in state SQ_Z
  logic signed [MW-1:0] sq_sel;
  logic [MW-1:0] sq_mag;
  logic [2*MW-1:0] sq_prod;

  always_comb begin
    sq_sel  = (state == SQ_Y) ? {y_q[AW-1], y_q} : {z_q[AW-1], z_q};
    sq_mag  = sq_sel[MW-1] ? MW'(-sq_sel) : MW'(sq_sel);
    sq_prod = sq_mag * sq_mag;
  end

  // one bit-pair step of the integer square root
  logic [NW:0] root_sum;
  logic root_take;

  always_comb begin
    root_sum  = {1'b0, root} + {1'b0, root_bit};
    root_take = {1'b0, rad} >= root_sum;
  end

  // absolute x and the horizontal magnitude
  logic signed [MW-1:0] x_ext;
  logic [MW-1:0] ax;
  logic [AW-1:0] r;

  always_comb begin
    x_ext = {x_q[AW-1], x_q};
    ax    = x_ext[MW-1] ? MW'(-x_ext) : MW'(x_ext);
    r     = root[AW-1:0];
  end

  // one CORDIC vectoring rotation
  logic signed [VW-1:0] dx, dy;
  logic signed [GW-1:0] atan_step;

  always_comb begin
    dx = cy >>> step;
    dy = cx >>> step;
    atan_step = GW'(signed'({2'b0, tta_pkg::ATAN_TAB[step]}));
  end

  // drive decision against the dead band
  logic [DW+1:0] elev_lo, tgt_hi;
  logic go_extend, go_retract;

  always_comb begin
    elev_lo    = {2'b0, elev} + {{(DW-tta_pkg::DEADBAND_W+2){1'b0}}, deadband};
    tgt_hi     = {2'b0, target_q} + {{(DW-tta_pkg::DEADBAND_W+2){1'b0}}, deadband};
    go_extend  = elev_lo < {2'b0, target_q};
    go_retract = {2'b0, elev} > tgt_hi;
  end

  // load the result register once it is free
  logic result_load;

  assign result_load = (state == FINISH) && (!out_valid || out_ready);

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  // sequencer, working registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      out_valid      <= 1'b0;
      deadband       <= tta_pkg::DEADBAND_RESET;
      max_target     <= tta_pkg::MAX_TARGET_RESET;
      stored_feather <= tta_pkg::FEATHER_RESET;
      stored_target  <= '0;
    end else begin
      // take configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          tta_pkg::REG_DEADBAND:   deadband   <= cfg_data[tta_pkg::DEADBAND_W-1:0];
          tta_pkg::REG_MAX_TARGET: max_target <= cfg_data[DW-1:0];
          default: ;
        endcase
      end

      // raise the result when loaded, drop it once taken
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            stored_feather <= feather_next;
            stored_target  <= target_next;
            target_q       <= eff_next;
            x_q            <= accel_x;
            y_q            <= accel_y;
            z_q            <= accel_z;
            state          <= SQ_Y;
          end
        end
        SQ_Y: begin
          rad   <= sq_prod[NW-1:0];
          state <= SQ_Z;
        end
        SQ_Z: begin
          rad      <= rad + sq_prod[NW-1:0];
          root     <= '0;
          root_bit <= {2'b01, {(NW-2){1'b0}}};
          state    <= ROOT;
        end
        ROOT: begin
          if (root_take) begin
            rad  <= rad - root_sum[NW-1:0];
            root <= (root >> 1) + root_bit;
          end else begin
            root <= root >> 1;
          end
          root_bit <= root_bit >> 2;
          if (root_bit[0]) begin
            state <= SETUP;
          end
        end
        SETUP: begin
          // name the degenerate cases directly
          if (ax == '0) begin
            elev  <= tta_pkg::ANGLE_ZERO;
            state <= FINISH;
          end else if (r == '0) begin
            elev  <= tta_pkg::ANGLE_RIGHT;
            state <= FINISH;
          end else if (ax == {1'b0, r}) begin
            elev  <= tta_pkg::ANGLE_HALF;
            state <= FINISH;
          end else begin
            cx    <= {4'b0, r, {AW{1'b0}}};
            cy    <= {3'b0, ax, {AW{1'b0}}};
            ang   <= '0;
            step  <= '0;
            state <= ROTATE;
          end
        end
        ROTATE: begin
          if (cy > 0) begin
            cx  <= cx + dx;
            cy  <= cy - dy;
            ang <= ang + atan_step;
          end else begin
            cx  <= cx - dx;
            cy  <= cy + dy;
            ang <= ang - atan_step;
          end
          step <= step + 1'b1;
          if (step == LastStep) begin
            state <= CLAMP;
          end
        end
        CLAMP: begin
          if (ang < 0) begin
            elev <= tta_pkg::ANGLE_ZERO;
          end else if (ang > tta_pkg::ANGLE_LIMIT) begin
            elev <= tta_pkg::ANGLE_RIGHT;
          end else begin
            elev <= ang[tta_pkg::ANGLE_FRAC +: DW];
          end
          state <= FINISH;
        end
        FINISH: begin
          // hold until the result register is free
          if (result_load) begin
            elevation_degrees <= elev;
            effective_target  <= target_q;
            if (go_extend) begin
              drive <= tta_pkg::DRIVE_EXTEND;
            end else if (go_retract) begin
              drive <= tta_pkg::DRIVE_RETRACT;
            end else begin
              drive <= tta_pkg::DRIVE_STOP;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ROTATE |-> step <= LastStep)
    else $error("rotation counter overran");

  a_elev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elevation_degrees <= tta_pkg::ANGLE_RIGHT)
    else $error("elevation above ninety degrees");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive == tta_pkg::DRIVE_STOP || drive == tta_pkg::DRIVE_EXTEND ||
                   drive == tta_pkg::DRIVE_RETRACT))
    else $error("invalid drive code");
`endif

endmodule
